/* hdl/anem_pkg.sv */
// ----------------------------------------------------------------------------
// anem_pkg
// shared widths, codes and controller/datapath bundles for the wind unit
// ----------------------------------------------------------------------------
package anem_pkg;

  localparam int HISTORY_DEPTH = 120;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = 16 + IDX_W;

  localparam int DIVD_W        = 52;
  localparam int DIVS_W        = 40;
  localparam int CNT_W         = $clog2(DIVD_W + 1);

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 20;

  localparam logic [16:0] RATE_SCALE = 17'd100000;
  localparam logic [15:0] RPM_SCALE  = 16'd60000;

  localparam logic [15:0] WINDOW_RST = 16'd1000;
  localparam logic [7:0]  PPR_RST    = 8'd1;
  localparam logic [19:0] UM_RST     = 20'd1000;

  localparam logic [19:0] MAX20 = 20'hFFFFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_PPR    = 2'd1,
    CFG_UM     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_RATE, OP_RPM, OP_SPEED, OP_GUST, OP_SHORT, OP_LONG
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    prep_delta;
    logic    prep_prod;
    logic    div_start;
    logic    div_capture;
    div_op_t div_op;
    logic    store;
    logic    sweep_start;
    logic    out_load;
  } anem_cmd_t;

  typedef struct packed {
    logic window_ok;
    logic div_done;
    logic sweep_done;
    logic out_busy;
  } anem_status_t;

endpackage

/* hdl/anem_ifs.sv */
// ----------------------------------------------------------------------------
// anem_ifs
// valid/ready channels for measurement items and statistics results
// ----------------------------------------------------------------------------
interface anem_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] total_pulses;
  modport source (output valid, output now_ms, output total_pulses, input ready);
  modport sink   (input valid, input now_ms, input total_pulses, output ready);
endinterface

interface anem_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] pulse_rate_x100;
  logic [15:0] cup_rpm;
  logic [15:0] speed_mm_s;
  logic [15:0] gust_mm_s;
  logic [15:0] short_mean_mm_s;
  logic [15:0] long_mean_mm_s;
  logic [15:0] peak_mm_s;
  logic [6:0]  history_fill;
  modport source (output valid, output pulse_rate_x100, output cup_rpm, output speed_mm_s,
                  output gust_mm_s, output short_mean_mm_s, output long_mean_mm_s,
                  output peak_mm_s, output history_fill, input ready);
  modport sink   (input valid, input pulse_rate_x100, input cup_rpm, input speed_mm_s,
                  input gust_mm_s, input short_mean_mm_s, input long_mean_mm_s,
                  input peak_mm_s, input history_fill, output ready);
endinterface

/* hdl/anem_div.sv */
// ----------------------------------------------------------------------------
// anem_div
// restoring divider, one quotient bit per cycle, iteration count per request
// ----------------------------------------------------------------------------
module anem_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [anem_pkg::DIVD_W-1:0] dividend,
  input  logic [anem_pkg::DIVS_W-1:0] divisor,
  input  logic [anem_pkg::CNT_W-1:0]  iters,
  output logic [anem_pkg::DIVD_W-1:0] quotient,
  output logic                        done
);
  import anem_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? DIVS_W'(trial - {1'b0, dvs_r}) : trial[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

/* hdl/anem_dp.sv */
// ----------------------------------------------------------------------------
// anem_dp
// datapath: config, measurement math, history ring, sweep sums, output register
// ----------------------------------------------------------------------------
module anem_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [anem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [anem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  anem_pkg::anem_cmd_t            cmd,
  output anem_pkg::anem_status_t         status,
  anem_in_if.sink                        in_bus,
  anem_out_if.source                     out_bus
);
  import anem_pkg::*;

  logic [15:0] window_r;
  logic [7:0]  ppr_r;
  logic [19:0] um_r;

  logic [31:0] now_r, total_r, last_time_r, last_pulse_r;
  logic [31:0] elapsed;
  logic [31:0] delta_r, divs_r;
  logic [7:0]  pprs_r;
  logic [DIVD_W-1:0] prod_rate_r, prod_rpm_r, prod_spd_r;
  logic [DIVS_W-1:0] div_ppr_r;

  logic [19:0] rate_r;
  logic [15:0] rpm_r, speed_r, gust_r, short_r, long_r, peak_r;

  logic [15:0]       hist_mem [HISTORY_DEPTH];
  logic [IDX_W-1:0]  wp_r;
  logic [FILL_W-1:0] fill_r;

  logic              sweep_act_r;
  logic [IDX_W-1:0]  idx_r;
  logic [15:0]       rd_r;
  logic              rd_v_r, rd_last_r, rd_a3_r, rd_a10_r;
  logic [SUM_W-1:0]  sum3_r, sum10_r, sumall_r;
  logic [IDX_W:0]    age_raw, age;

  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic [CNT_W-1:0]  div_iters;
  logic [DIVD_W-1:0] quo;
  logic              div_done;

  logic        out_valid_r;
  logic [19:0] o_rate_r;
  logic [15:0] o_rpm_r, o_speed_r, o_gust_r, o_short_r, o_long_r, o_peak_r;
  logic [6:0]  o_fill_r;

  // config writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      ppr_r    <= PPR_RST;
      um_r     <= UM_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW: window_r <= cfg_wdata[15:0];
        CFG_PPR:    ppr_r    <= cfg_wdata[7:0];
        CFG_UM:     um_r     <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  assign elapsed = now_r - last_time_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r   <= in_bus.now_ms;
      total_r <= in_bus.total_pulses;
    end
    if (cmd.prep_delta) begin
      delta_r <= total_r - last_pulse_r;
      divs_r  <= (elapsed == 32'd0) ? 32'd1 : elapsed;
      pprs_r  <= (ppr_r == 8'd0) ? 8'd1 : ppr_r;
    end
    if (cmd.prep_prod) begin
      prod_rate_r <= DIVD_W'(delta_r * RATE_SCALE);
      prod_rpm_r  <= DIVD_W'(delta_r * RPM_SCALE);
      prod_spd_r  <= DIVD_W'(delta_r * um_r);
      div_ppr_r   <= DIVS_W'(divs_r * pprs_r);
    end
  end

  // divider operand select
  always_comb begin
    div_dvd   = prod_rate_r;
    div_dvs   = DIVS_W'(divs_r);
    div_iters = CNT_W'(DIVD_W);
    case (cmd.div_op)
      OP_RATE:  ;
      OP_RPM: begin
        div_dvd = prod_rpm_r;
        div_dvs = div_ppr_r;
      end
      OP_SPEED: div_dvd = prod_spd_r;
      OP_GUST: begin
        div_dvd   = {sum3_r, {(DIVD_W-SUM_W){1'b0}}};
        div_dvs   = (fill_r < FILL_W'(3)) ? DIVS_W'(fill_r) : DIVS_W'(3);
        div_iters = CNT_W'(SUM_W);
      end
      OP_SHORT: begin
        div_dvd   = {sum10_r, {(DIVD_W-SUM_W){1'b0}}};
        div_dvs   = (fill_r < FILL_W'(10)) ? DIVS_W'(fill_r) : DIVS_W'(10);
        div_iters = CNT_W'(SUM_W);
      end
      OP_LONG: begin
        div_dvd   = {sumall_r, {(DIVD_W-SUM_W){1'b0}}};
        div_dvs   = DIVS_W'(fill_r);
        div_iters = CNT_W'(SUM_W);
      end
      default: ;
    endcase
  end

  anem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_iters),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_op)
        OP_RATE:  rate_r  <= (quo > DIVD_W'(MAX20)) ? MAX20 : quo[19:0];
        OP_RPM:   rpm_r   <= (quo > DIVD_W'(MAX16)) ? MAX16 : quo[15:0];
        OP_SPEED: speed_r <= (quo > DIVD_W'(MAX16)) ? MAX16 : quo[15:0];
        OP_GUST:  gust_r  <= quo[15:0];
        OP_SHORT: short_r <= quo[15:0];
        OP_LONG:  long_r  <= quo[15:0];
        default:  ;
      endcase
    end
  end

  // history ring and measurement state
  always_ff @(posedge clk) begin
    if (cmd.store) hist_mem[wp_r] <= speed_r;
    rd_r <= hist_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      fill_r       <= '0;
      peak_r       <= '0;
      last_time_r  <= '0;
      last_pulse_r <= '0;
    end else if (cmd.store) begin
      wp_r         <= (wp_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + IDX_W'(1);
      if (fill_r < FILL_W'(HISTORY_DEPTH)) fill_r <= fill_r + FILL_W'(1);
      if (speed_r > peak_r) peak_r <= speed_r;
      last_time_r  <= now_r;
      last_pulse_r <= total_r;
    end
  end

  // age of entry idx relative to the newest sample
  assign age_raw = (IDX_W+1)'(wp_r) + (IDX_W+1)'(HISTORY_DEPTH - 1) - (IDX_W+1)'(idx_r);
  assign age     = (age_raw >= (IDX_W+1)'(HISTORY_DEPTH))
                   ? age_raw - (IDX_W+1)'(HISTORY_DEPTH) : age_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_act_r <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      idx_r       <= '0;
    end else begin
      rd_v_r    <= sweep_act_r;
      rd_last_r <= sweep_act_r && (FILL_W'(idx_r) + FILL_W'(1) == fill_r);
      rd_a3_r   <= age < (IDX_W+1)'(3);
      rd_a10_r  <= age < (IDX_W+1)'(10);
      if (cmd.sweep_start) begin
        sweep_act_r <= 1'b1;
        idx_r       <= '0;
      end else if (sweep_act_r) begin
        idx_r <= idx_r + IDX_W'(1);
        if (FILL_W'(idx_r) + FILL_W'(1) == fill_r) sweep_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      sum3_r   <= '0;
      sum10_r  <= '0;
      sumall_r <= '0;
    end else if (rd_v_r) begin
      sumall_r <= sumall_r + SUM_W'(rd_r);
      if (rd_a3_r)  sum3_r  <= sum3_r + SUM_W'(rd_r);
      if (rd_a10_r) sum10_r <= sum10_r + SUM_W'(rd_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_rate_r  <= rate_r;
      o_rpm_r   <= rpm_r;
      o_speed_r <= speed_r;
      o_gust_r  <= gust_r;
      o_short_r <= short_r;
      o_long_r  <= long_r;
      o_peak_r  <= peak_r;
      o_fill_r  <= 7'(fill_r);
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.pulse_rate_x100 = o_rate_r;
  assign out_bus.cup_rpm         = o_rpm_r;
  assign out_bus.speed_mm_s      = o_speed_r;
  assign out_bus.gust_mm_s       = o_gust_r;
  assign out_bus.short_mean_mm_s = o_short_r;
  assign out_bus.long_mean_mm_s  = o_long_r;
  assign out_bus.peak_mm_s       = o_peak_r;
  assign out_bus.history_fill    = o_fill_r;

  assign status.window_ok  = elapsed >= {16'd0, window_r};
  assign status.div_done   = div_done;
  assign status.sweep_done = rd_last_r;
  assign status.out_busy   = out_valid_r;
endmodule

/* hdl/anem_ctrl.sv */
// ----------------------------------------------------------------------------
// anem_ctrl
// sequencer: window check, three rate divisions, store, sweep, three means
// ----------------------------------------------------------------------------
module anem_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  anem_pkg::anem_status_t status,
  output anem_pkg::anem_cmd_t    cmd,
  output logic                   in_ready
);
  import anem_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PROD, S_DIV_GO, S_DIV_WAIT,
    S_STORE, S_SWEEP_GO, S_SWEEP_WAIT, S_OUT
  } state_t;

  state_t  state_r;
  div_op_t op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_RATE;
    end else begin
      case (state_r)
        S_IDLE:   if (in_fire) state_r <= S_CHECK;
        S_CHECK:  state_r <= status.window_ok ? S_PROD : S_IDLE;
        S_PROD: begin
          op_r    <= OP_RATE;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (status.div_done) begin
            if (op_r == OP_SPEED) begin
              state_r <= S_STORE;
            end else if (op_r == OP_LONG) begin
              state_r <= S_OUT;
            end else begin
              op_r    <= div_op_t'(op_r + 3'd1);
              state_r <= S_DIV_GO;
            end
          end
        end
        S_STORE:    state_r <= S_SWEEP_GO;
        S_SWEEP_GO: state_r <= S_SWEEP_WAIT;
        S_SWEEP_WAIT: begin
          if (status.sweep_done) begin
            op_r    <= OP_GUST;
            state_r <= S_DIV_GO;
          end
        end
        S_OUT:    if (!status.out_busy) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.div_op      = op_r;
    cmd.load_in     = (state_r == S_IDLE) && in_fire;
    cmd.prep_delta  = state_r == S_CHECK;
    cmd.prep_prod   = state_r == S_PROD;
    cmd.div_start   = state_r == S_DIV_GO;
    cmd.div_capture = (state_r == S_DIV_WAIT) && status.div_done;
    cmd.store       = state_r == S_STORE;
    cmd.sweep_start = state_r == S_SWEEP_GO;
    cmd.out_load    = (state_r == S_OUT) && !status.out_busy;
  end

  assign in_ready = state_r == S_IDLE;
endmodule

/* hdl/anemometer_wind_statistics_unit.sv */
// ----------------------------------------------------------------------------
// anemometer_wind_statistics_unit
// cup anemometer statistics: rate, rpm, speed, gust/short/long means, peak
// ----------------------------------------------------------------------------
// an item inside the window is dropped after the window check, with no result
// measured item: three rate divisions, store, sweep over the filled history entries, three mean divisions, output load
// throughput: one item at a time; set by the shared bit-serial divider and the history sweep
// one result may wait in the output register while the next item is taken
// reset: synchronous active low; config to defaults, times, counts and peak to zero
// history ring content is not cleared, only entries below the fill count are read
module anemometer_wind_statistics_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [anem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [anem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  anem_in_if.sink                         in_bus,
  anem_out_if.source                      out_bus
);
  import anem_pkg::*;

  anem_cmd_t    cmd;
  anem_status_t status;
  logic         in_ready;

  // input transfer happens only while the sequencer is idle
  assign in_bus.ready = in_ready;

  anem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_bus.valid),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // datapath owns config, history ring, divider and output register
  anem_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );
endmodule

/* hdl/anem_chk.sv */
// ----------------------------------------------------------------------------
// anem_chk
// port-level checks for the wind statistics unit
// ----------------------------------------------------------------------------
module anem_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] speed,
  input logic [15:0] gust,
  input logic [15:0] short_mean,
  input logic [15:0] long_mean,
  input logic [15:0] peak,
  input logic [6:0]  fill
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> peak >= speed && peak >= gust && peak >= short_mean && peak >= long_mean)
    else $error("peak below a reported speed");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fill != 7'd0)
    else $error("result with empty history");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind anemometer_wind_statistics_unit anem_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .speed      (out_bus.speed_mm_s),
  .gust       (out_bus.gust_mm_s),
  .short_mean (out_bus.short_mean_mm_s),
  .long_mean  (out_bus.long_mean_mm_s),
  .peak       (out_bus.peak_mm_s),
  .fill       (out_bus.history_fill)
);
